// ===== sv/rti_pkg.sv =====
`timescale 1ns / 1ps
package rti_pkg;

    localparam int COORD_BITS      = 16;
    localparam int COORD_FRAC_BITS = 8;
    localparam int DIST_BITS       = 32;
    localparam int DIR_W           = 16;
    localparam int DIR_FRAC        = 13;
    localparam int NORM_W          = 16;
    localparam int REG_W           = 48;
    localparam int THR_W           = 32;
    localparam int CFG_AW          = 3;

    localparam int T_SHIFT = 16 + DIR_FRAC - COORD_FRAC_BITS;

    // edge, origin offset, cross products, dot sums (with room for negation)
    localparam int EW   = COORD_BITS + 1;
    localparam int PVW  = DIR_W + EW + 1;
    localparam int QVW  = 2 * EW + 1;
    localparam int SUMW = EW + QVW + 3;

    // dividend width: covers both the shifted numerator and den << DIST_BITS
    localparam int WD = SUMW + ((T_SHIFT > DIST_BITS) ? T_SHIFT : DIST_BITS) + 1;

    localparam logic [CFG_AW-1:0] CFG_VERTEX_A  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_VERTEX_B  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_VERTEX_C  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_NORMAL    = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_THRESHOLD = 3'd4;

    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] org;
        logic [2:0][DIR_W-1:0]      dir;
    } t_ray;

    typedef struct packed {
        logic hit;
        logic neg;
        logic tneg;
        logic ovf;
        t_ray ray;
    } t_side;

    // field idx of a packed vertex register; parts beyond the register read as zero
    function automatic logic signed [COORD_BITS-1:0] coord_field(
        input logic [REG_W-1:0] r,
        input int               idx
    );
        logic [3*COORD_BITS+REG_W-1:0] ext;
        ext = {{(3*COORD_BITS){1'b0}}, r};
        ext = ext >> (idx * COORD_BITS);
        return ext[COORD_BITS-1:0];
    endfunction

endpackage

// ===== sv/rti_div.sv =====
`timescale 1ns / 1ps
module rti_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [rti_pkg::WD-1:0]            i_num,
    input  logic [rti_pkg::SUMW-1:0]          i_den,
    input  rti_pkg::t_side                    i_side,
    output logic                              o_valid,
    output logic [rti_pkg::DIST_BITS-1:0]     o_quot,
    output rti_pkg::t_side                    o_side
);
    import rti_pkg::*;

    localparam int NS = DIST_BITS;

    logic                 r_vld  [NS];
    logic [DIST_BITS-1:0] r_q    [NS];
    t_side                r_side [NS];
    logic [WD-1:0]        r_rem  [NS-1];
    logic [SUMW-1:0]      r_den  [NS-1];

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < NS; k++) begin : g_st
        localparam int BIT = NS - 1 - k;
        logic                 v_in;
        logic [WD-1:0]        rem_in;
        logic [SUMW-1:0]      den_in;
        logic [DIST_BITS-1:0] q_in;
        t_side                side_in;
        logic [WD-1:0]        trial;
        logic                 ge;
        logic [DIST_BITS-1:0] n_q;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = i_num;
            assign den_in  = i_den;
            assign q_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign q_in    = r_q[k-1];
            assign side_in = r_side[k-1];
        end

        assign trial = WD'(den_in) << BIT;
        assign ge    = (rem_in >= trial);

        always_comb begin
            n_q      = q_in;
            n_q[BIT] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= v_in;
            end
            r_q[k]    <= n_q;
            r_side[k] <= side_in;
        end

        if (k < NS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[k] <= ge ? (rem_in - trial) : rem_in;
                r_den[k] <= den_in;
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_quot  = r_q[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

// ===== sv/ray_triangle_intersect.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Signals                                     Transfer
// request   in         i_start, i_origin_*, i_direction_*          i_start && !o_busy
// result    out        o_valid, o_hit_found .. o_normal_z          o_valid, one cycle
// config    in         i_cfg_we, i_cfg_addr, i_cfg_wdata           i_cfg_we
//
// One ray per cycle; o_busy is always low. Most of the pipeline is the
// one-bit-per-stage pipelined divider for t. Reset is synchronous and
// active low; it clears the valid bits and the registers (threshold to 1).
// The receiver cannot stall, so the pipeline always advances.
module ray_triangle_intersect (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    output logic                                     o_busy,
    input  logic signed [rti_pkg::COORD_BITS-1:0]    i_origin_x,
    input  logic signed [rti_pkg::COORD_BITS-1:0]    i_origin_y,
    input  logic signed [rti_pkg::COORD_BITS-1:0]    i_origin_z,
    input  logic signed [rti_pkg::DIR_W-1:0]         i_direction_x,
    input  logic signed [rti_pkg::DIR_W-1:0]         i_direction_y,
    input  logic signed [rti_pkg::DIR_W-1:0]         i_direction_z,
    input  logic                                     i_cfg_we,
    input  logic [rti_pkg::CFG_AW-1:0]               i_cfg_addr,
    input  logic [rti_pkg::REG_W-1:0]                i_cfg_wdata,
    output logic                                     o_valid,
    output logic                                     o_hit_found,
    output logic                                     o_back_face,
    output logic signed [rti_pkg::DIST_BITS-1:0]     o_distance,
    output logic signed [rti_pkg::COORD_BITS-1:0]    o_point_x,
    output logic signed [rti_pkg::COORD_BITS-1:0]    o_point_y,
    output logic signed [rti_pkg::COORD_BITS-1:0]    o_point_z,
    output logic signed [rti_pkg::NORM_W-1:0]        o_normal_x,
    output logic signed [rti_pkg::NORM_W-1:0]        o_normal_y,
    output logic signed [rti_pkg::NORM_W-1:0]        o_normal_z
);
    import rti_pkg::*;

    localparam int M1W = DIR_W + EW;
    localparam int M2W = 2 * EW;
    localparam int PRW = DIST_BITS + DIR_W;
    localparam int PTW = PRW + 2;

    // configuration
    logic [REG_W-1:0] r_va, r_vb, r_vc, r_norm;
    logic [THR_W-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va   <= '0;
            r_vb   <= '0;
            r_vc   <= '0;
            r_norm <= '0;
            r_thr  <= THR_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_VERTEX_A:  r_va   <= i_cfg_wdata;
                CFG_VERTEX_B:  r_vb   <= i_cfg_wdata;
                CFG_VERTEX_C:  r_vc   <= i_cfg_wdata;
                CFG_NORMAL:    r_norm <= i_cfg_wdata;
                CFG_THRESHOLD: r_thr  <= i_cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    logic accept;
    assign accept = i_start && !o_busy;

    t_ray in_ray;
    assign in_ray.org = {i_origin_z, i_origin_y, i_origin_x};
    assign in_ray.dir = {i_direction_z, i_direction_y, i_direction_x};

    // stage 1: edges and origin offset
    logic                    r1_v;
    logic signed [EW-1:0]    r1_e1 [3];
    logic signed [EW-1:0]    r1_e2 [3];
    logic signed [EW-1:0]    r1_tv [3];
    logic signed [DIR_W-1:0] r1_d  [3];
    t_ray                    r1_ray;

    // stage 2: cross product terms
    logic                    r2_v;
    logic signed [M1W-1:0]   r2_pa [3];
    logic signed [M1W-1:0]   r2_pb [3];
    logic signed [M2W-1:0]   r2_qa [3];
    logic signed [M2W-1:0]   r2_qb [3];
    logic signed [EW-1:0]    r2_e1 [3];
    logic signed [EW-1:0]    r2_e2 [3];
    logic signed [EW-1:0]    r2_tv [3];
    logic signed [DIR_W-1:0] r2_d  [3];
    t_ray                    r2_ray;

    // stage 3: pvec, qvec
    logic                    r3_v;
    logic signed [PVW-1:0]   r3_pv [3];
    logic signed [QVW-1:0]   r3_qv [3];
    logic signed [EW-1:0]    r3_e1 [3];
    logic signed [EW-1:0]    r3_e2 [3];
    logic signed [EW-1:0]    r3_tv [3];
    logic signed [DIR_W-1:0] r3_d  [3];
    t_ray                    r3_ray;

    // stage 4: dot product terms
    logic                        r4_v;
    logic signed [EW+PVW-1:0]    r4_det [3];
    logic signed [EW+PVW-1:0]    r4_un  [3];
    logic signed [DIR_W+QVW-1:0] r4_vn  [3];
    logic signed [EW+QVW-1:0]    r4_tn  [3];
    t_ray                        r4_ray;

    // stage 5: sums
    logic                   r5_v;
    logic signed [SUMW-1:0] r5_det, r5_un, r5_vn, r5_tn;
    t_ray                   r5_ray;

    // stage 6: fold the determinant sign
    logic                   r6_v;
    logic                   r6_neg;
    logic signed [SUMW-1:0] r6_det, r6_un, r6_vn, r6_tn;
    t_ray                   r6_ray;

    // stage 7: tests and dividend
    logic            r7_v;
    logic [WD-1:0]   r7_num;
    logic [SUMW-1:0] r7_den;
    t_side           r7_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            r1_v <= accept;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end

        for (int i = 0; i < 3; i++) begin
            r1_e1[i] <= coord_field(r_vb, i) - coord_field(r_va, i);
            r1_e2[i] <= coord_field(r_vc, i) - coord_field(r_va, i);
            r1_tv[i] <= $signed(in_ray.org[i]) - coord_field(r_va, i);
            r1_d[i]  <= $signed(in_ray.dir[i]);
        end
        r1_ray <= in_ray;

        r2_pa[0] <= r1_d[1] * r1_e2[2];
        r2_pb[0] <= r1_d[2] * r1_e2[1];
        r2_pa[1] <= r1_d[2] * r1_e2[0];
        r2_pb[1] <= r1_d[0] * r1_e2[2];
        r2_pa[2] <= r1_d[0] * r1_e2[1];
        r2_pb[2] <= r1_d[1] * r1_e2[0];
        r2_qa[0] <= r1_tv[1] * r1_e1[2];
        r2_qb[0] <= r1_tv[2] * r1_e1[1];
        r2_qa[1] <= r1_tv[2] * r1_e1[0];
        r2_qb[1] <= r1_tv[0] * r1_e1[2];
        r2_qa[2] <= r1_tv[0] * r1_e1[1];
        r2_qb[2] <= r1_tv[1] * r1_e1[0];
        r2_e1  <= r1_e1;
        r2_e2  <= r1_e2;
        r2_tv  <= r1_tv;
        r2_d   <= r1_d;
        r2_ray <= r1_ray;

        for (int i = 0; i < 3; i++) begin
            r3_pv[i] <= r2_pa[i] - r2_pb[i];
            r3_qv[i] <= r2_qa[i] - r2_qb[i];
        end
        r3_e1  <= r2_e1;
        r3_e2  <= r2_e2;
        r3_tv  <= r2_tv;
        r3_d   <= r2_d;
        r3_ray <= r2_ray;

        for (int i = 0; i < 3; i++) begin
            r4_det[i] <= r3_e1[i] * r3_pv[i];
            r4_un[i]  <= r3_tv[i] * r3_pv[i];
            r4_vn[i]  <= r3_d[i]  * r3_qv[i];
            r4_tn[i]  <= r3_e2[i] * r3_qv[i];
        end
        r4_ray <= r3_ray;

        r5_det <= r4_det[0] + r4_det[1] + r4_det[2];
        r5_un  <= r4_un[0]  + r4_un[1]  + r4_un[2];
        r5_vn  <= r4_vn[0]  + r4_vn[1]  + r4_vn[2];
        r5_tn  <= r4_tn[0]  + r4_tn[1]  + r4_tn[2];
        r5_ray <= r4_ray;

        r6_neg <= r5_det[SUMW-1];
        r6_det <= r5_det[SUMW-1] ? -r5_det : r5_det;
        r6_un  <= r5_det[SUMW-1] ? -r5_un  : r5_un;
        r6_vn  <= r5_det[SUMW-1] ? -r5_vn  : r5_vn;
        r6_tn  <= r5_det[SUMW-1] ? -r5_tn  : r5_tn;
        r6_ray <= r5_ray;
    end

    logic                 s7_miss;
    logic signed [SUMW:0] s7_uv;
    logic [SUMW-1:0]      s7_mag;
    logic [WD-1:0]        s7_num;

    always_comb begin
        s7_uv   = r6_un + r6_vn;
        s7_miss = (r6_det == '0)
               || ($unsigned(r6_det) < SUMW'(r_thr))
               || r6_un[SUMW-1] || r6_vn[SUMW-1]
               || (r6_un > r6_det)
               || (s7_uv > (SUMW+1)'(r6_det));
        s7_mag  = r6_tn[SUMW-1] ? $unsigned(-r6_tn) : $unsigned(r6_tn);
        s7_num  = (WD'(s7_mag) << T_SHIFT) + WD'($unsigned(r6_det) >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else begin
            r7_v <= r6_v;
        end
        r7_num        <= s7_num;
        r7_den        <= $unsigned(r6_det);
        r7_side.hit   <= !s7_miss;
        r7_side.neg   <= r6_neg;
        r7_side.tneg  <= r6_tn[SUMW-1];
        r7_side.ovf   <= (s7_num >= (WD'($unsigned(r6_det)) << DIST_BITS));
        r7_side.ray   <= r6_ray;
    end

    logic                 dv_v;
    logic [DIST_BITS-1:0] dv_q;
    t_side                dv_side;

    rti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r7_v),
        .i_num   (r7_num),
        .i_den   (r7_den),
        .i_side  (r7_side),
        .o_valid (dv_v),
        .o_quot  (dv_q),
        .o_side  (dv_side)
    );

    // stage 8: saturate and sign t
    logic                        r8_v;
    logic signed [DIST_BITS-1:0] r8_tq;
    t_side                       r8_side;

    logic [DIST_BITS-1:0] s8_lim;
    logic [DIST_BITS-1:0] s8_q;

    always_comb begin
        s8_lim = dv_side.tneg ? (DIST_BITS'(1) << (DIST_BITS - 1))
                              : ((DIST_BITS'(1) << (DIST_BITS - 1)) - DIST_BITS'(1));
        s8_q   = (dv_side.ovf || (dv_q > s8_lim)) ? s8_lim : dv_q;
    end

    // stage 9: t * direction
    logic                        r9_v;
    logic signed [PRW-1:0]       r9_prod [3];
    logic signed [DIST_BITS-1:0] r9_tq;
    t_side                       r9_side;

    // stage 10: round, offset, saturate
    logic                         r_out_v;
    logic                         r_out_hit;
    logic                         r_out_back;
    logic signed [DIST_BITS-1:0]  r_out_dist;
    logic signed [COORD_BITS-1:0] r_out_pt [3];
    logic [REG_W-1:0]             r_out_norm;

    logic [PRW-1:0]          s10_pm  [3];
    logic [PRW:0]            s10_rnd [3];
    logic signed [PTW-1:0]   s10_p   [3];
    logic signed [COORD_BITS-1:0] s10_sat [3];

    localparam logic signed [PTW-1:0] CMAX = PTW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [PTW-1:0] CMIN = -CMAX - PTW'(1);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s10_pm[i]  = r9_prod[i][PRW-1] ? $unsigned(-r9_prod[i]) : $unsigned(r9_prod[i]);
            s10_rnd[i] = ((PRW+1)'(s10_pm[i]) + ((PRW+1)'(1) << (T_SHIFT - 1))) >> T_SHIFT;
            if (r9_prod[i][PRW-1]) begin
                s10_p[i] = PTW'($signed(r9_side.ray.org[i])) - $signed(PTW'(s10_rnd[i]));
            end else begin
                s10_p[i] = PTW'($signed(r9_side.ray.org[i])) + $signed(PTW'(s10_rnd[i]));
            end
            if (s10_p[i] > CMAX) begin
                s10_sat[i] = CMAX[COORD_BITS-1:0];
            end else if (s10_p[i] < CMIN) begin
                s10_sat[i] = CMIN[COORD_BITS-1:0];
            end else begin
                s10_sat[i] = s10_p[i][COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v    <= 1'b0;
            r9_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r8_v    <= dv_v;
            r9_v    <= r8_v;
            r_out_v <= r9_v;
        end

        r8_tq   <= dv_side.tneg ? $signed(-s8_q) : $signed(s8_q);
        r8_side <= dv_side;

        for (int i = 0; i < 3; i++) begin
            r9_prod[i] <= r8_tq * $signed(r8_side.ray.dir[i]);
        end
        r9_tq   <= r8_tq;
        r9_side <= r8_side;

        // drop everything on a miss
        r_out_hit  <= r9_side.hit;
        r_out_back <= r9_side.hit && r9_side.neg;
        r_out_dist <= r9_side.hit ? r9_tq : '0;
        for (int i = 0; i < 3; i++) begin
            r_out_pt[i] <= r9_side.hit ? s10_sat[i] : '0;
        end
        r_out_norm <= r9_side.hit ? r_norm : '0;
    end

    assign o_valid     = r_out_v;
    assign o_hit_found = r_out_hit;
    assign o_back_face = r_out_back;
    assign o_distance  = r_out_dist;
    assign o_point_x   = r_out_pt[0];
    assign o_point_y   = r_out_pt[1];
    assign o_point_z   = r_out_pt[2];
    assign o_normal_x  = r_out_norm[NORM_W-1:0];
    assign o_normal_y  = r_out_norm[2*NORM_W-1:NORM_W];
    assign o_normal_z  = r_out_norm[3*NORM_W-1:2*NORM_W];

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import rti_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic                  hit;
        logic                  back;
        logic [DIST_BITS-1:0]  tdist;
        logic [COORD_BITS-1:0] px, py, pz;
        logic [NORM_W-1:0]     nx, ny, nz;
    } t_hit_rec;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_start = 1'b0;
    logic                         o_busy;
    logic signed [COORD_BITS-1:0] i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    logic signed [DIR_W-1:0]      i_direction_x = '0, i_direction_y = '0, i_direction_z = '0;
    logic                         i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]            i_cfg_addr = '0;
    logic [REG_W-1:0]             i_cfg_wdata = '0;
    logic                         o_valid, o_hit_found, o_back_face;
    logic signed [DIST_BITS-1:0]  o_distance;
    logic signed [COORD_BITS-1:0] o_point_x, o_point_y, o_point_z;
    logic signed [NORM_W-1:0]     o_normal_x, o_normal_y, o_normal_z;

    ray_triangle_intersect DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow of the triangle registers
    logic [REG_W-1:0] vert_a = '0, vert_b = '0, vert_c = '0, tri_normal = '0;
    logic [THR_W-1:0] par_thr = THR_W'(1);

    t_ray     ray_queue[$];
    t_hit_rec pending_hits[$];
    int       idle_pct = 0;
    int       errors = 0;
    int       rays_sent = 0;
    int       hits_seen = 0;
    int       results_seen = 0;
    int       cycles = 0;

    function automatic t_hit_rec trace_ray(t_ray r);
        t_hit_rec res;
        logic signed [127:0] av[3], e1[3], e2[3], tv[3], dv[3], pv[3], qv[3];
        logic signed [127:0] det, un, vn, tn, mag, qt, lim, thr;
        logic signed [63:0]  tq, prod, pm, rr, p, org;
        logic                neg, tneg;
        res = '{default: '0};
        for (int i = 0; i < 3; i++) begin
            av[i] = $signed(vert_a[16*i +: 16]);
            e1[i] = $signed(vert_b[16*i +: 16]) - av[i];
            e2[i] = $signed(vert_c[16*i +: 16]) - av[i];
            tv[i] = $signed(r.org[i]) - av[i];
            dv[i] = $signed(r.dir[i]);
        end
        pv[0] = dv[1] * e2[2] - dv[2] * e2[1];
        pv[1] = dv[2] * e2[0] - dv[0] * e2[2];
        pv[2] = dv[0] * e2[1] - dv[1] * e2[0];
        qv[0] = tv[1] * e1[2] - tv[2] * e1[1];
        qv[1] = tv[2] * e1[0] - tv[0] * e1[2];
        qv[2] = tv[0] * e1[1] - tv[1] * e1[0];
        det = e1[0] * pv[0] + e1[1] * pv[1] + e1[2] * pv[2];
        un  = tv[0] * pv[0] + tv[1] * pv[1] + tv[2] * pv[2];
        vn  = dv[0] * qv[0] + dv[1] * qv[1] + dv[2] * qv[2];
        tn  = e2[0] * qv[0] + e2[1] * qv[1] + e2[2] * qv[2];
        neg = det < 0;
        if (neg) begin
            det = -det; un = -un; vn = -vn; tn = -tn;
        end
        thr = $signed({96'b0, par_thr});
        if (det == 0 || det < thr) return res;
        if (un < 0 || vn < 0 || un > det || un + vn > det) return res;
        tneg = tn < 0;
        mag  = tneg ? -tn : tn;
        qt   = ((mag <<< T_SHIFT) + (det >>> 1)) / det;
        lim  = tneg ? 128'sd2147483648 : 128'sd2147483647;
        if (qt > lim) qt = lim;
        tq = tneg ? -qt[63:0] : qt[63:0];
        res.hit   = 1'b1;
        res.back  = neg;
        res.tdist = tq[DIST_BITS-1:0];
        for (int i = 0; i < 3; i++) begin
            org  = $signed(r.org[i]);
            prod = tq * $signed(r.dir[i]);
            pm   = prod < 0 ? -prod : prod;
            rr   = (pm + (64'sd1 <<< (T_SHIFT - 1))) >>> T_SHIFT;
            p    = prod < 0 ? org - rr : org + rr;
            if (p > 32767) p = 32767;
            if (p < -32768) p = -32768;
            case (i)
                0: res.px = p[15:0];
                1: res.py = p[15:0];
                default: res.pz = p[15:0];
            endcase
        end
        res.nx = tri_normal[15:0];
        res.ny = tri_normal[31:16];
        res.nz = tri_normal[47:32];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        if (errors <= 30)
            $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, results_seen);
    endtask

    // driver: one ray transaction per accepted edge
    t_ray cur_ray;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                pending_hits.push_back(trace_ray(cur_ray));
                rays_sent++;
            end
            if (ray_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                cur_ray = ray_queue.pop_front();
                i_origin_x    <= cur_ray.org[0];
                i_origin_y    <= cur_ray.org[1];
                i_origin_z    <= cur_ray.org[2];
                i_direction_x <= cur_ray.dir[0];
                i_direction_y <= cur_ray.dir[1];
                i_direction_z <= cur_ray.dir[2];
                i_start <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_hit_rec w;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_hits.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                w = pending_hits.pop_front();
                if (w.hit) hits_seen++;
                if (o_hit_found !== w.hit) report_mismatch("hit_found", o_hit_found, w.hit);
                if (o_back_face !== w.back) report_mismatch("back_face", o_back_face, w.back);
                if (o_distance !== w.tdist) report_mismatch("distance", o_distance, w.tdist);
                if (o_point_x !== w.px) report_mismatch("point_x", o_point_x, w.px);
                if (o_point_y !== w.py) report_mismatch("point_y", o_point_y, w.py);
                if (o_point_z !== w.pz) report_mismatch("point_z", o_point_z, w.pz);
                if (o_normal_x !== w.nx) report_mismatch("normal_x", o_normal_x, w.nx);
                if (o_normal_y !== w.ny) report_mismatch("normal_y", o_normal_y, w.ny);
                if (o_normal_z !== w.nz) report_mismatch("normal_z", o_normal_z, w.nz);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [REG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_VERTEX_A:  vert_a = data;
            CFG_VERTEX_B:  vert_b = data;
            CFG_VERTEX_C:  vert_c = data;
            CFG_NORMAL:    tri_normal = data;
            CFG_THRESHOLD: par_thr = data[THR_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [REG_W-1:0] pack3(int x, int y, int z);
        logic [15:0] fx, fy, fz;
        fx = 16'(x); fy = 16'(y); fz = 16'(z);
        return {fz, fy, fx};
    endfunction

    function automatic logic [REG_W-1:0] rand48();
        return {16'($urandom_range(16'hFFFF)), $urandom()};
    endfunction

    task automatic push_ray(int ox, int oy, int oz, int dx, int dy, int dz);
        t_ray r;
        r.org[0] = 16'(ox); r.org[1] = 16'(oy); r.org[2] = 16'(oz);
        r.dir[0] = 16'(dx); r.dir[1] = 16'(dy); r.dir[2] = 16'(dz);
        ray_queue.push_back(r);
    endtask

    function automatic int clamp16(int v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    // aim at a random point inside the current triangle
    task automatic push_aimed_ray();
        int a[3], tgt[3], org[3], d[3], u, v, big;
        u = $urandom_range(256);
        v = $urandom_range(256 - u);
        big = 1;
        for (int i = 0; i < 3; i++) begin
            a[i]   = $signed(vert_a[16*i +: 16]);
            tgt[i] = a[i] + (u * ($signed(vert_b[16*i +: 16]) - a[i])
                          + v * ($signed(vert_c[16*i +: 16]) - a[i])) / 256;
            org[i] = clamp16(tgt[i] + $signed($urandom_range(8191)) - 4096);
            d[i]   = tgt[i] - org[i];
        end
        while (big) begin
            big = 0;
            for (int i = 0; i < 3; i++)
                if (d[i] > 32767 || d[i] < -32768) big = 1;
            if (big)
                for (int i = 0; i < 3; i++) d[i] = d[i] >>> 1;
        end
        // flip the direction now and then for negative t
        if ($urandom_range(4) == 0)
            for (int i = 0; i < 3; i++) d[i] = clamp16(-d[i]);
        push_ray(org[0], org[1], org[2], d[0], d[1], d[2]);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (ray_queue.size() > 0 || i_start || pending_hits.size() > 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // unmapped indexes must be ignored
        write_reg(3'd5, rand48());
        write_reg(3'd6, rand48());
        write_reg(3'd7, {REG_W{1'b1}});

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_VERTEX_A, pack3(0, 0, 0));
                    write_reg(CFG_VERTEX_B, pack3(1024, 0, 0));
                    write_reg(CFG_VERTEX_C, pack3(0, 1024, 0));
                    write_reg(CFG_NORMAL, pack3(0, 0, 16384));
                    write_reg(CFG_THRESHOLD, REG_W'(1));
                end
                1: begin
                    write_reg(CFG_VERTEX_A, pack3($urandom_range(4095) - 2048,
                        $urandom_range(4095) - 2048, $urandom_range(4095) - 2048));
                    write_reg(CFG_VERTEX_B, pack3($urandom_range(4095) - 2048,
                        $urandom_range(4095) - 2048, $urandom_range(4095) - 2048));
                    write_reg(CFG_VERTEX_C, pack3($urandom_range(4095) - 2048,
                        $urandom_range(4095) - 2048, $urandom_range(4095) - 2048));
                    write_reg(CFG_NORMAL, rand48());
                    write_reg(CFG_THRESHOLD, REG_W'($urandom_range(65535)));
                end
                2: write_reg(CFG_THRESHOLD, '0);
                3: write_reg(CFG_THRESHOLD, REG_W'(32'hFFFF_FFFF));
                4: begin
                    write_reg(CFG_VERTEX_A, pack3(32767, -32768, 32767));
                    write_reg(CFG_VERTEX_B, pack3(-32768, 32767, 32767));
                    write_reg(CFG_VERTEX_C, pack3(-32768, -32768, -32768));
                    write_reg(CFG_NORMAL, {REG_W{1'b1}});
                    write_reg(CFG_THRESHOLD, REG_W'(1));
                end
                5: begin
                    write_reg(CFG_VERTEX_B, vert_a);
                    write_reg(CFG_THRESHOLD, '0);
                end
                default: begin
                    write_reg(CFG_VERTEX_A, rand48());
                    write_reg(CFG_VERTEX_B, rand48());
                    write_reg(CFG_VERTEX_C, rand48());
                    write_reg(CFG_NORMAL, rand48());
                    write_reg(CFG_THRESHOLD, REG_W'($urandom()));
                end
            endcase
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 71;
                2: idle_pct = 0;
                default: idle_pct = 21;
            endcase
            if (ph == 0) begin
                push_ray(256, 256, 512, 0, 0, -8192);        // interior
                push_ray(0, 0, 512, 0, 0, -8192);            // on the first vertex
                push_ray(512, 512, 512, 0, 0, -8192);        // on the far edge
                push_ray(513, 512, 512, 0, 0, -8192);        // just past the far edge
                push_ray(-1, 100, 512, 0, 0, -8192);         // u below zero
                push_ray(100, -1, 512, 0, 0, -8192);         // v below zero
                push_ray(256, 256, -512, 0, 0, 8192);        // back face
                push_ray(256, 256, -512, 0, 0, -8192);       // negative t
                push_ray(256, 256, 512, 8192, 0, 0);         // parallel
                push_ray(256, 256, 512, 0, 0, 0);            // zero direction
                push_ray(256, 256, 32767, 0, 0, -1);         // saturated t
                push_ray(256, 256, -32768, 0, 0, 1);
                push_ray(32767, 32767, 32767, -32768, -32768, -32768);
                push_ray(-32768, -32768, -32768, 32767, 32767, 32767);
                push_ray(100, 100, 256, 32767, 32767, -32768);
                push_ray(-32768, 32767, 1, -32768, 32767, -1);
            end
            for (int n = 0; n < 240; n++) begin
                if ($urandom_range(99) < 60)
                    push_aimed_ray();
                else
                    push_ray($urandom_range(65535), $urandom_range(65535),
                        $urandom_range(65535), $urandom_range(65535),
                        $urandom_range(65535), $urandom_range(65535));
            end
            wait_idle();
        end

        if (pending_hits.size() > 0) begin
            errors += pending_hits.size();
            $display("%0d results never arrived", pending_hits.size());
        end
        $display("Sent %0d rays over 8 triangle setups, %0d results checked, %0d hits",
            rays_sent, results_seen, hits_seen);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("Verification failed");
        end
        $finish;
    end
endmodule
